// ----- sv/bcc_pkg.sv -----
`timescale 1ns / 1ps
// bcc_pkg: codes and reset values for the button click / hold classifier
// no dependencies; imported by button_click_hold_classifier

package bcc_pkg;

  // event kinds on the input stream
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_TICK    = 2'd2;

  // gesture codes on the output stream
  localparam logic [1:0] G_NONE   = 2'd0;
  localparam logic [1:0] G_SINGLE = 2'd1;
  localparam logic [1:0] G_DOUBLE = 2'd2;
  localparam logic [1:0] G_HOLD   = 2'd3;

  // phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_WINDOW = 3'd2;
  localparam logic [2:0] PH_SECOND = 3'd3;
  localparam logic [2:0] PH_HOLD   = 3'd4;

  // register indexes and reset values
  localparam logic REG_HOLD   = 1'b0;
  localparam logic REG_WINDOW = 1'b1;
  localparam logic [15:0] HOLD_TICKS_RST   = 16'd2000;
  localparam logic [15:0] WINDOW_TICKS_RST = 16'd1000;

  typedef struct packed {
    logic       unexpected;
    logic [1:0] gesture;
  } bcc_result_t;

endpackage

// ----- sv/button_click_hold_classifier.sv -----
`timescale 1ns / 1ps
// button_click_hold_classifier: top level, phase register, countdown and output skid
// depends on bcc_pkg
//
// Usage: button events (press, release, tick) enter on the s_axis stream,
// one item per handshake, the kind in s_axis_tdata[1:0]. Each accepted item
// gives exactly one result item on the m_axis stream: gesture code and the
// unexpected flag. hold_ticks (byte address 0) and double_window_ticks
// (byte address 4) are to be written over the APB port only while the block
// is idle; the block itself does not enforce this. Throughput: one item per
// cycle while s_axis_tready is high; phase and countdown update in the accept
// cycle through one decrement and a small phase decode. Results are held in
// an output register plus a one-entry skid stage, which part the two sides:
// while the receiver stalls, one more item is taken into the skid stage,
// then s_axis_tready drops until the output register drains.
// Reset: phase idle, timer stopped, registers at 2000 and 1000 ticks,
// both result stages empty. No clearing pass.

module button_click_hold_classifier #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] event_kind, [7:2] zero
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] gesture, [2] unexpected, [7:3] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcc_pkg::*;

  localparam logic [32:0] TimerMax = (33'd1 << TIMER_BITS) - 33'd1;

  logic [15:0]           hold_ticks_q, window_ticks_q;
  logic [2:0]            phase_q, phase_d;
  logic [TIMER_BITS-1:0] count_q, count_d, count_dec;
  logic                  out_valid_q, skid_valid_q;
  bcc_result_t           out_q, skid_q, res;
  logic                  push, pop, cfg_wr;
  logic [1:0]            ev;

  function automatic logic [TIMER_BITS-1:0] arm_load(input logic [15:0] ticks);
    logic [32:0] w;
    w = {17'd0, ticks};
    if (w == 33'd0) w = 33'd1;
    if (w > TimerMax) w = TimerMax;
    return w[TIMER_BITS-1:0];
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_WINDOW) ? {16'd0, window_ticks_q} : {16'd0, hold_ticks_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q   <= HOLD_TICKS_RST;
      window_ticks_q <= WINDOW_TICKS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HOLD) hold_ticks_q <= pwdata[15:0];
      else window_ticks_q <= pwdata[15:0];
    end
  end

  // classification of one item
  assign ev        = s_axis_tdata[1:0];
  assign count_dec = count_q - TIMER_BITS'(1);

  always_comb begin
    phase_d        = phase_q;
    count_d        = count_q;
    res.gesture    = G_NONE;
    res.unexpected = 1'b0;
    unique case (ev)
      EV_TICK: begin
        if (count_q != '0) begin
          count_d = count_dec;
          if (count_dec == '0) begin
            // one-shot timeout
            priority if (phase_q == PH_WINDOW) begin
              phase_d = PH_IDLE;
            end else if (phase_q == PH_FIRST || phase_q == PH_SECOND) begin
              res.gesture = G_HOLD;
              phase_d     = PH_HOLD;
            end else begin
              res.unexpected = 1'b1;
            end
          end
        end
      end
      EV_PRESS: begin
        priority if (phase_q == PH_IDLE) begin
          phase_d = PH_FIRST;
          count_d = arm_load(hold_ticks_q);
        end else if (phase_q == PH_WINDOW) begin
          phase_d = PH_SECOND;
          count_d = arm_load(hold_ticks_q);
        end else if (phase_q == PH_SECOND) begin
          // bounce while second press is down
        end else begin
          res.unexpected = 1'b1;
        end
      end
      EV_RELEASE: begin
        priority if (phase_q == PH_IDLE) begin
          // button may have been down at reset
        end else if (phase_q == PH_FIRST) begin
          res.gesture = G_SINGLE;
          phase_d     = PH_WINDOW;
          count_d     = arm_load(window_ticks_q);
        end else if (phase_q == PH_HOLD) begin
          count_d = '0;
          phase_d = PH_IDLE;
        end else if (phase_q == PH_SECOND) begin
          count_d     = '0;
          res.gesture = G_DOUBLE;
          phase_d     = PH_IDLE;
        end else begin
          res.unexpected = 1'b1;
        end
      end
      default: res.unexpected = 1'b1;
    endcase
  end

  assign s_axis_tready = ~skid_valid_q;
  assign push          = s_axis_tvalid & s_axis_tready;
  assign pop           = out_valid_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else if (push) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) skid_q <= res;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  a_idle_timer_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE || phase_q == PH_HOLD) |-> (count_q == '0))
    else $error("timer running in idle or holding phase");

  a_armed_timer_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FIRST || phase_q == PH_WINDOW || phase_q == PH_SECOND)
      |-> (count_q != '0))
    else $error("timer stopped in a timed phase");
`endif

endmodule
